// ===== rtl/apss_pkg.sv =====
// Package for the alpha projection sprite splitter.
// Sizes, result kind codes and reset values shared by the core and its testbench.
// No dependencies.
package apss_pkg;

    // Geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 4096;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COL_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_CNT_W   = $clog2(MAX_HEIGHT);

    // Beat fields
    localparam int ALPHA_W     = 8;
    localparam int IDX_W       = 12;
    localparam int MIN_RUN_W   = 9;

    // Results per band: one band record plus at most MAX_RUNS column runs
    localparam int MAX_RESULTS = 22;
    localparam int MAX_RUNS    = MAX_RESULTS - 1;
    localparam int RUN_CNT_W   = $clog2(MAX_RUNS + 1);

    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RESET = MIN_RUN_W'(10);

    // Result kind codes
    localparam logic KIND_BAND = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

endpackage

// ===== rtl/apss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read returns the old contents when the same address is written in that cycle.
// No dependencies.
module apss_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read; read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/alpha_projection_sprite_splitter_core.sv =====
// Alpha projection sprite splitter. Pixels (alpha bytes) enter one per cycle in raster order
// and mark a per-column ink bitmap held in a single-bit RAM of MAX_WIDTH entries. When an
// empty row closes a band of ink rows, the core emits a band record and then walks the whole
// bitmap, one column per cycle through the RAM read port unless a found run waits for the
// result register, emitting each column run wider than min_run_width and clearing each
// entry behind it. The input is stalled for the walk and until the last result is handed
// over. An image that ends inside a band runs the same walk with no results. After reset
// the same walk clears the bitmap, with s_ready held low. Otherwise one pixel is taken each
// cycle. The last result of a band carries m_last.
// Depends on apss_pkg and apss_ram.
module alpha_projection_sprite_splitter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration
    input  logic                            cfg_we,
    input  logic [apss_pkg::MIN_RUN_W-1:0]  cfg_wdata,
    // Pixel beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [apss_pkg::ALPHA_W-1:0]    s_alpha,
    input  logic                            s_end_of_row,
    input  logic                            s_end_of_image,
    // Result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [apss_pkg::IDX_W-1:0]      m_start_index,
    output logic [apss_pkg::IDX_W-1:0]      m_stop_index,
    output logic                            m_last
);
    import apss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t                 state_reg;
    logic [MIN_RUN_W-1:0]   min_run_reg;

    // Scan state
    logic                   row_ink_reg;
    logic                   in_band_reg;
    logic [ROW_CNT_W-1:0]   band_top_reg;
    logic [ROW_CNT_W-1:0]   row_cnt_reg;
    logic [COL_W-1:0]       col_cnt_reg;
    logic [COL_W-1:0]       row_len_reg;

    // Walk state
    logic [COL_W-1:0]       ptr_reg;
    logic                   dv_reg;
    logic [ADDR_W-1:0]      col_reg;
    logic                   open_reg;
    logic [ADDR_W-1:0]      run_start_reg;
    logic [RUN_CNT_W-1:0]   run_cnt_reg;
    logic                   emit_en_reg;

    // Result held back until we know whether it is the last one
    logic                   pend_kind_reg;
    logic [IDX_W-1:0]       pend_start_reg;
    logic [IDX_W-1:0]       pend_stop_reg;

    // Output register
    logic                   m_valid_reg;
    logic                   m_kind_reg;
    logic [IDX_W-1:0]       m_start_reg;
    logic [IDX_W-1:0]       m_stop_reg;
    logic                   m_last_reg;

    // RAM ports
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic                   ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic                   ram_rdata;

    // Pixel side
    logic                   s_accept;
    logic                   in_range;
    logic                   row_ink_now;
    logic [COL_W-1:0]       col_next;
    logic                   row_end;
    logic                   band_open;
    logic                   band_close;
    logic                   band_drop;

    // Walk side
    logic                   out_free;
    logic                   out_load;
    logic                   eval;
    logic                   run_found;
    logic [COL_W-1:0]       run_width;
    logic                   stall;
    logic                   advance;
    logic                   ptr_live;
    logic                   walk_done;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Per-pixel decode
    assign in_range    = (col_cnt_reg < COL_W'(MAX_WIDTH));
    assign row_ink_now = row_ink_reg || (in_range && (s_alpha != '0));
    assign col_next    = in_range ? col_cnt_reg + COL_W'(1) : col_cnt_reg;
    assign row_end     = s_end_of_row || s_end_of_image;
    assign band_open   = row_end && row_ink_now && !in_band_reg;
    assign band_close  = row_end && !row_ink_now && in_band_reg;
    // image ends while a band is (or just became) open
    assign band_drop   = s_end_of_image && (band_open || (in_band_reg && !band_close));

    // Walk step: evaluate returned column, stall only when a run needs the output slot
    assign eval      = dv_reg && (COL_W'(col_reg) < row_len_reg);
    assign run_width = COL_W'(col_reg) - COL_W'(run_start_reg);
    assign run_found = eval && !ram_rdata && open_reg && emit_en_reg
                       && (run_width > COL_W'(min_run_reg))
                       && (run_cnt_reg < RUN_CNT_W'(MAX_RUNS));
    assign stall     = run_found && !out_free;
    assign advance   = (state_reg == ST_WALK) && !stall;
    assign ptr_live  = (ptr_reg < COL_W'(MAX_WIDTH));
    assign walk_done = !ptr_live && !dv_reg;

    // Output register loads on a run hand-off or on the final flush
    assign out_load  = ((state_reg == ST_WALK) && run_found && out_free)
                       || ((state_reg == ST_FLUSH) && out_free);

    // RAM port selection: pixels set ink, the walk clears behind its read pointer
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[ADDR_W-1:0];
        if (state_reg == ST_WALK) begin
            ram_we    = advance && dv_reg;
            ram_waddr = col_reg;
            ram_wdata = 1'b0;
            ram_re    = advance && ptr_live;
        end else begin
            ram_we    = s_accept && in_range && (s_alpha != '0);
            ram_waddr = col_cnt_reg[ADDR_W-1:0];
            ram_wdata = 1'b1;
        end
    end

    apss_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_ink_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_run_reg <= MIN_RUN_RESET;
        end else if (cfg_we) begin
            min_run_reg <= cfg_wdata;
        end
    end

    // Row and band tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ink_reg  <= 1'b0;
            in_band_reg  <= 1'b0;
            band_top_reg <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            row_len_reg  <= '0;
        end else if (s_accept) begin
            if (row_end) begin
                row_len_reg <= col_next;
                col_cnt_reg <= '0;
                row_ink_reg <= 1'b0;
                if (s_end_of_image) begin
                    in_band_reg  <= 1'b0;
                    band_top_reg <= '0;
                    row_cnt_reg  <= '0;
                end else begin
                    if (band_open) begin
                        in_band_reg  <= 1'b1;
                        band_top_reg <= row_cnt_reg;
                    end else if (band_close) begin
                        in_band_reg <= 1'b0;
                    end
                    if (row_cnt_reg < ROW_CNT_W'(MAX_HEIGHT - 1)) begin
                        row_cnt_reg <= row_cnt_reg + ROW_CNT_W'(1);
                    end
                end
            end else begin
                col_cnt_reg <= col_next;
                row_ink_reg <= row_ink_now;
            end
        end
    end

    // Sequencer: band close / drop walk, run detection and result hand-off.
    // Reset starts a silent walk that clears the bitmap.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WALK;
            m_valid_reg   <= 1'b0;
            ptr_reg       <= '0;
            dv_reg        <= 1'b0;
            open_reg      <= 1'b0;
            run_cnt_reg   <= '0;
            emit_en_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (band_close || band_drop)) begin
                        state_reg   <= ST_WALK;
                        ptr_reg     <= '0;
                        dv_reg      <= 1'b0;
                        open_reg    <= 1'b0;
                        run_cnt_reg <= '0;
                        emit_en_reg <= band_close;
                        // band record: top row and the empty row that closes it
                        pend_kind_reg  <= KIND_BAND;
                        pend_start_reg <= IDX_W'(band_top_reg);
                        pend_stop_reg  <= IDX_W'(row_cnt_reg);
                    end
                end
                ST_WALK: begin
                    if (walk_done) begin
                        state_reg <= emit_en_reg ? ST_FLUSH : ST_IDLE;
                    end else if (advance) begin
                        if (eval) begin
                            if (ram_rdata && !open_reg) begin
                                open_reg      <= 1'b1;
                                run_start_reg <= col_reg;
                            end else if (!ram_rdata && open_reg) begin
                                open_reg <= 1'b0;
                            end
                        end
                        // a new run pushes the held result out as not last
                        if (run_found) begin
                            m_kind_reg     <= pend_kind_reg;
                            m_start_reg    <= pend_start_reg;
                            m_stop_reg     <= pend_stop_reg;
                            m_last_reg     <= 1'b0;
                            pend_kind_reg  <= KIND_RUN;
                            pend_start_reg <= IDX_W'(run_start_reg);
                            pend_stop_reg  <= IDX_W'(col_reg);
                            run_cnt_reg    <= run_cnt_reg + RUN_CNT_W'(1);
                        end
                        dv_reg  <= ptr_live;
                        col_reg <= ptr_reg[ADDR_W-1:0];
                        if (ptr_live) begin
                            ptr_reg <= ptr_reg + COL_W'(1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        m_kind_reg  <= pend_kind_reg;
                        m_start_reg <= pend_start_reg;
                        m_stop_reg  <= pend_stop_reg;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_start_index = m_start_reg;
    assign m_stop_index  = m_stop_reg;
    assign m_last        = m_last_reg;

endmodule

// ===== dv/alpha_projection_sprite_splitter_core_tb.sv =====
// Self-checking bench for alpha_projection_sprite_splitter_core: drives pixel beats, predicts
// band records and column runs in-line, and checks every result beat in order.
// Depends on apss_pkg and the core RTL.
`timescale 1ns / 1ps

module alpha_projection_sprite_splitter_core_tb;
    import apss_pkg::*;

    localparam int ROW_BITS    = 320;               // widest ink mask the bench builds
    localparam int DRAIN       = MAX_WIDTH + 16;    // column walk plus margin
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [ALPHA_W-1:0] alpha;
        logic               eor;
        logic               eoi;
    } pixel_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] start_idx;
        logic [IDX_W-1:0] stop_idx;
        logic             last;
    } sprite_rec_t;

    typedef enum {END_ROW, END_IMAGE, END_IMAGE_ONLY} row_end_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_we         = 1'b0;
    logic [MIN_RUN_W-1:0] cfg_wdata      = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [ALPHA_W-1:0]   s_alpha        = '0;
    logic                 s_end_of_row   = 1'b0;
    logic                 s_end_of_image = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_kind;
    logic [IDX_W-1:0]     m_start_index;
    logic [IDX_W-1:0]     m_stop_index;
    logic                 m_last;

    alpha_projection_sprite_splitter_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_alpha        (s_alpha),
        .s_end_of_row   (s_end_of_row),
        .s_end_of_image (s_end_of_image),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_start_index  (m_start_index),
        .m_stop_index   (m_stop_index),
        .m_last         (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shared bench state
    pixel_t      pixel_fifo[$];
    sprite_rec_t pending_records[$];
    int          err_count    = 0;
    int          phase_count  = 0;
    int          src_gap_max  = 3;
    int          sink_gap_max = 3;
    int          cycles       = 0;
    logic        hold_go      = 1'b0;
    int          hold_left    = 0;

    // Predictor state
    bit                   ink_map [MAX_WIDTH];
    bit                   row_ink     = 1'b0;
    bit                   band_open   = 1'b0;
    bit [IDX_W-1:0]       band_top    = '0;
    bit [IDX_W-1:0]       row_num     = '0;
    int unsigned          col_num     = 0;
    int unsigned          closing_len = 0;
    bit [MIN_RUN_W-1:0]   min_run     = MIN_RUN_RESET;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Advance the projection state by one pixel; queue the band and its runs on a close
    task automatic project_pixel(input logic [ALPHA_W-1:0] a, input logic eor,
                                 input logic eoi);
        sprite_rec_t batch[$];
        int          run_start;
        bit          run_open;
        run_start = 0;
        run_open  = 1'b0;
        if (col_num < MAX_WIDTH) begin
            if (a != '0) begin
                row_ink          = 1'b1;
                ink_map[col_num] = 1'b1;
            end
            col_num++;
        end
        if (!(eor || eoi))
            return;
        closing_len = col_num;
        col_num     = 0;
        if (row_ink && !band_open) begin
            band_open = 1'b1;
            band_top  = row_num;
        end else if (!row_ink && band_open) begin
            band_open = 1'b0;
            batch.insert(batch.size(), sprite_rec_t'{KIND_BAND, band_top, row_num, 1'b0});
            // walk the columns of the closing row; a run still open at the edge is lost
            for (int j = 0; j < int'(closing_len); j++) begin
                if (ink_map[j] && !run_open) begin
                    run_open  = 1'b1;
                    run_start = j;
                end else if (!ink_map[j] && run_open) begin
                    run_open = 1'b0;
                    if (j - run_start > int'(min_run) && batch.size() < MAX_RESULTS)
                        batch.insert(batch.size(),
                                     sprite_rec_t'{KIND_RUN, IDX_W'(run_start), IDX_W'(j),
                                                   1'b0});
                end
            end
            ink_map = '{default: 1'b0};
        end
        row_ink = 1'b0;
        if (eoi) begin
            if (band_open)
                ink_map = '{default: 1'b0};
            band_open = 1'b0;
            band_top  = '0;
            row_num   = '0;
        end else if (int'(row_num) < MAX_HEIGHT - 1) begin
            row_num++;
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            pending_records.insert(pending_records.size(), batch[i]);
    endtask

    // Input side: track config writes and predict from every accepted pixel beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                min_run = cfg_wdata;
            if (s_valid && s_ready)
                project_pixel(s_alpha, s_end_of_row, s_end_of_image);
        end
    end

    // Pixel driver, fed from pixel_fifo with a random gap after each beat
    always @(posedge aclk) begin : drive_pixels
        pixel_t nxt;
        int     gap_left;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else if (s_valid && !s_ready) begin
            // hold the beat until it is taken
        end else if (gap_left != 0) begin
            s_valid  <= 1'b0;
            gap_left = gap_left - 1;
        end else if (pixel_fifo.size() != 0) begin
            nxt             = pixel_fifo.pop_front();
            s_valid        <= 1'b1;
            s_alpha        <= nxt.alpha;
            s_end_of_row   <= nxt.eor;
            s_end_of_image <= nxt.eoi;
            gap_left        = $urandom_range(0, src_gap_max);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_go)
            hold_left <= 800;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor and ready driver
    always @(posedge aclk) begin : check_results
        sprite_rec_t want;
        int          sink_wait;
        int          w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_records.size() == 0) begin
                    report_mismatch($sformatf("result beat with none expected (kind %0d %0d..%0d)",
                                              m_kind, m_start_index, m_stop_index));
                end else begin
                    want = pending_records.pop_front();
                    if (m_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_kind, want.kind));
                    if (m_start_index !== want.start_idx)
                        report_mismatch($sformatf("start_index %0d, want %0d",
                                                  m_start_index, want.start_idx));
                    if (m_stop_index !== want.stop_idx)
                        report_mismatch($sformatf("stop_index %0d, want %0d",
                                                  m_stop_index, want.stop_idx));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", m_last, want.last));
                end
                w = $urandom_range(0, sink_gap_max);
            end else if (sink_wait != 0) begin
                w = sink_wait - 1;
            end else begin
                w = 0;
            end
            sink_wait = w;
            m_ready  <= (w == 0) && (hold_left == 0);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit [ROW_BITS-1:0] span(input int lo, input int hi);
        bit [ROW_BITS-1:0] m;
        m = '0;
        for (int c = lo; c <= hi; c++)
            m[c] = 1'b1;
        return m;
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_ink();
        case ($urandom_range(0, 7))
            0:       return 8'd1;
            1:       return 8'd255;
            default: return ALPHA_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic queue_row(input int width, input bit [ROW_BITS-1:0] ink,
                             input row_end_t how);
        pixel_t p;
        for (int c = 0; c < width; c++) begin
            p.alpha = ink[c] ? pick_ink() : '0;
            p.eor   = (c == width - 1) && (how != END_IMAGE_ONLY);
            p.eoi   = (c == width - 1) && (how != END_ROW);
            pixel_fifo.insert(pixel_fifo.size(), p);
            phase_count++;
        end
    endtask

    // Well-formed image with random content; rows are sometimes ragged
    task automatic queue_image(input int max_w);
        int                rows, w, rw, lo, hi;
        bit [ROW_BITS-1:0] ink;
        row_end_t          how;
        rows = $urandom_range(2, 9);
        w    = $urandom_range(2, max_w);
        for (int r = 0; r < rows; r++) begin
            rw = ($urandom_range(0, 5) == 0) ? $urandom_range(1, max_w) : w;
            case ($urandom_range(0, 3))
                0: ink = '0;
                1: begin
                    lo  = $urandom_range(0, rw - 1);
                    hi  = $urandom_range(lo, rw - 1);
                    ink = span(lo, hi);
                end
                2: ink = {10{$urandom()}};
                default: ink = span(0, rw - 1);
            endcase
            if (r != rows - 1)
                how = END_ROW;
            else
                how = $urandom_range(0, 1) ? END_IMAGE : END_IMAGE_ONLY;
            queue_row(rw, ink, how);
        end
    endtask

    // Loose pixels with random markers
    task automatic queue_noise(input int n);
        pixel_t p;
        for (int i = 0; i < n; i++) begin
            p.alpha = $urandom_range(0, 1) ? pick_ink() : '0;
            p.eor   = ($urandom_range(0, 5) == 0);
            p.eoi   = ($urandom_range(0, 19) == 0);
            pixel_fifo.insert(pixel_fifo.size(), p);
            phase_count++;
        end
    endtask

    // Quiet point: everything sent, everything received, column walk finished
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pixel_fifo.size() != 0 || s_valid || pending_records.size() != 0);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_min_run(input int v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= MIN_RUN_W'(v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        bit [ROW_BITS-1:0] mask;
        int                run_cfg [5] = '{10, 2, 0, 256, 1};
        int                run_src [5] = '{3, 0, 0, 3, 0};
        int                run_sink[5] = '{3, 0, 3, 3, 3};
        int                run_w   [5] = '{14, 8, 8, 10, 8};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset threshold: a run of eleven columns passes, one of ten does not
        queue_row(13, span(0, 10), END_ROW);
        queue_row(13, '0, END_ROW);
        queue_row(12, span(0, 9), END_ROW);
        queue_row(12, '0, END_IMAGE);
        wait_idle();

        write_min_run(1);
        // Band with a run closed inside and one left open at the right edge
        queue_row(6, span(0, 2) | span(5, 5), END_ROW);
        queue_row(6, span(3, 3), END_ROW);
        queue_row(6, '0, END_ROW);
        // Band still open at image end: dropped, map must be cleared
        queue_row(4, span(1, 1), END_IMAGE);
        queue_row(3, span(0, 0), END_ROW);
        queue_row(3, '0, END_IMAGE_ONLY);
        // Ragged rows: the closing row sets the walk length
        queue_row(8, span(0, 7), END_ROW);
        queue_row(3, '0, END_ROW);
        queue_row(2, span(0, 0), END_ROW);
        queue_row(8, '0, END_IMAGE);
        wait_idle();

        // Cap on runs per band
        write_min_run(0);
        mask = '0;
        for (int c = 0; c < 46; c += 2)
            mask[c] = 1'b1;
        queue_row(46, mask, END_ROW);
        queue_row(46, '0, END_IMAGE);
        wait_idle();

        // Random phases over several thresholds
        for (int ph = 0; ph < 5; ph++) begin
            write_min_run(run_cfg[ph]);
            src_gap_max  = run_src[ph];
            sink_gap_max = run_sink[ph];
            phase_count  = 0;
            if (ph == 2) begin
                // receiver stalls while pixels keep coming
                @(posedge aclk);
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
                queue_row(4, span(0, 0) | span(2, 3), END_ROW);
                queue_row(4, '0, END_ROW);
                queue_row(4, span(1, 2), END_ROW);
                queue_row(4, '0, END_IMAGE);
            end
            while (phase_count < 20) begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise($urandom_range(1, 8));
                else
                    queue_image(run_w[ph]);
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
